### sv/mqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_pkg: shared types and constants of the MQ arithmetic encoder
// Command codes, probability tables, byte former result and output queue
// entry.
// ----------------------------------------------------------------------------
package mqe_pkg;

  localparam int A_W    = 16;
  localparam int C_W    = 28;
  localparam int CT_W   = 4;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 7;
  localparam int PW     = 6;
  localparam int NUM_PROB = 47;

  localparam logic [A_W-1:0]    A_INIT     = 16'h8000;
  localparam logic [CT_W-1:0]   CT_INIT    = 4'd12;
  localparam logic [CT_W-1:0]   CT_STUFF   = 4'd7;
  localparam logic [CT_W-1:0]   CT_PLAIN   = 4'd8;
  localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;
  localparam logic [C_W-1:0]    C_CARRY_MSK = 28'h7FFFFFF;
  localparam logic [C_W-1:0]    C_STUFF_MSK = 28'hFFFFF;
  localparam logic [C_W-1:0]    C_PLAIN_MSK = 28'h7FFFF;
  localparam logic [C_W-1:0]    C_FLUSH_OR  = 28'hFFFF;
  localparam logic [C_W-1:0]    C_FLUSH_SUB = 28'h8000;

  // Output queue sizing: one item emits at most three bytes.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_START  = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  localparam logic [15:0] QE_TAB [NUM_PROB] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601
  };

  localparam logic [PW-1:0] NMPS_TAB [NUM_PROB] = '{
    6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46
  };

  localparam logic [PW-1:0] NLPS_TAB [NUM_PROB] = '{
    6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46
  };

  localparam logic SW_TAB [NUM_PROB] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  // Result of forming one code byte from the pending byte and C.
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] pend;
    logic [C_W-1:0]    code;
    logic [CT_W-1:0]   count;
  } form_res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

endpackage
`default_nettype wire

### sv/mqe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_if: channel interfaces of the MQ arithmetic encoder
// Command channel and code byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mqe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] context_index;
  logic       decision;
  logic [6:0] context_value;

  modport source (output valid, cmd, context_index, decision, context_value,
                  input ready);
  modport sink   (input valid, cmd, context_index, decision, context_value,
                  output ready);
endinterface

interface mqe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

### sv/mq_arithmetic_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mq_arithmetic_encoder: MQ binary adaptive arithmetic encoder
// Command-driven MQ coder with context store, carry-holding pending byte and
// a code byte queue on the output.
// ----------------------------------------------------------------------------
// One command is taken per transfer and runs to completion before the next
// is taken. Start, load and an encode or load to a context at or above
// NUM_CONTEXTS end in their transfer cycle. An encode does context read, Qe
// lookup, interval subtract and decision and, if it renormalizes, n shifts
// (1 to 15) and an end step: the shift and byte-forming unit does one shift
// per cycle and forms a byte in the same cycle whenever the bit counter runs
// out. Flush does limit, compare, two shift and form pairs on the same byte
// former, and final and end steps. Code bytes go into a four-entry queue; a
// command is taken only while that queue holds at most one byte, so a
// waiting byte does not stop the next command. The last flag marks the
// final byte that a command produces; each byte waits in a hold register so
// that the flag is known when it is queued. Context states reset to zero
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module mq_arithmetic_encoder #(
  parameter int NUM_CONTEXTS = 19
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mqe_in_if.sink    in_ch,
  mqe_out_if.source out_ch
);

  localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int IW = (AW > 5) ? AW : 5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_SUB, ST_DEC, ST_SHIFT,
    ST_FLIM, ST_FCMP, ST_FSH1, ST_FFM1, ST_FSH2, ST_FFM2, ST_FFIN,
    ST_END
  } state_t;

  state_t state_r;

  // coder registers
  logic [mqe_pkg::A_W-1:0]    a_r;
  logic [mqe_pkg::C_W-1:0]    c_r;
  logic [mqe_pkg::CT_W-1:0]   ct_r;
  logic [mqe_pkg::BYTE_W-1:0] pend_r;
  logic                       dummy_r;

  // per-command working registers
  logic [AW-1:0]              addr_r;
  logic                       d_r;
  logic                       mps_r;
  logic [mqe_pkg::A_W-1:0]    qe_r;
  logic [mqe_pkg::ST_W-1:0]   nst_r;
  logic [mqe_pkg::C_W-1:0]    lim_r;
  logic [mqe_pkg::CT_W-1:0]   it_r;
  logic [mqe_pkg::BYTE_W-1:0] hold_r;
  logic                       hold_vld_r;

  logic                       accept;
  logic                       in_range;
  logic                       load_ok;
  logic [IW-1:0]              in_ctx_ext;
  logic [AW-1:0]              in_addr;

  logic [mqe_pkg::ST_W-1:0]   st;
  logic [mqe_pkg::PW-1:0]     idx;
  logic [mqe_pkg::PW-1:0]     idx_c;

  logic [mqe_pkg::A_W-1:0]    a_sh;
  logic [mqe_pkg::C_W-1:0]    c_sh;
  logic [mqe_pkg::CT_W-1:0]   ct_dec;
  logic                       form_now;
  logic [mqe_pkg::C_W-1:0]    form_code;
  mqe_pkg::form_res_t         fr;

  logic                       emit_now;
  logic [mqe_pkg::BYTE_W-1:0] emit_byte;
  logic                       push;
  mqe_pkg::out_item_t         push_item;
  mqe_pkg::out_item_t         head;
  logic [mqe_pkg::OUT_CW-1:0] q_count;
  logic                       q_not_empty;

  logic                       ctx_rd_en;
  logic [mqe_pkg::ST_W-1:0]   ctx_rd_data;
  logic                       ctx_we;
  logic [AW-1:0]              ctx_waddr;
  logic [mqe_pkg::ST_W-1:0]   ctx_wdata;

  // --------------------------------------------------------------------------
  // Input side: take a command only when idle and the queue has room for the
  // up to three bytes that it can produce.
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE) && (q_count <= mqe_pkg::OUT_CW'(1));
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ctx_ext  = IW'(in_ch.context_index);
  assign in_addr     = in_ctx_ext[AW-1:0];
  assign in_range    = (32'(in_ch.context_index) < NUM_CONTEXTS);
  assign load_ok     = in_range && (in_ch.context_value < 7'(2 * mqe_pkg::NUM_PROB));

  assign ctx_rd_en = accept && (in_ch.cmd == mqe_pkg::CMD_ENCODE) && in_range;

  // --------------------------------------------------------------------------
  // Probability lookup on the stored state; clamp a bad index to the last row.
  // --------------------------------------------------------------------------
  assign st    = ctx_rd_data;
  assign idx   = st[mqe_pkg::ST_W-1:1];
  assign idx_c = (idx >= mqe_pkg::PW'(mqe_pkg::NUM_PROB))
               ? mqe_pkg::PW'(mqe_pkg::NUM_PROB - 1) : idx;

  // --------------------------------------------------------------------------
  // Shift and byte-forming unit: one renormalization shift per cycle; the
  // byte former is shared with the two flush steps.
  // --------------------------------------------------------------------------
  assign a_sh      = {a_r[mqe_pkg::A_W-2:0], 1'b0};
  assign c_sh      = {c_r[mqe_pkg::C_W-2:0], 1'b0};
  assign ct_dec    = ct_r - 1'b1;
  assign form_code = (state_r == ST_SHIFT) ? c_sh : c_r;
  assign form_now  = ((state_r == ST_SHIFT) && (ct_dec == '0)) ||
                     (state_r == ST_FFM1) || (state_r == ST_FFM2);

  mqe_byte_former u_former (
    .pend  (pend_r),
    .code  (form_code),
    .dummy (dummy_r),
    .res   (fr)
  );

  // Each new byte pushes the held one out with last clear; the end step
  // pushes the held byte with last set.
  always_comb begin
    emit_now  = 1'b0;
    emit_byte = fr.data;
    if (form_now) begin
      emit_now = fr.emit;
    end else if (state_r == ST_FFIN) begin
      emit_now  = (pend_r != mqe_pkg::BYTE_FF);
      emit_byte = pend_r;
    end
    push           = hold_vld_r && (emit_now || (state_r == ST_END));
    push_item.data = hold_r;
    push_item.last = (state_r == ST_END);
  end

  // Context write: a load at transfer, or the state update of an encode.
  always_comb begin
    ctx_we    = 1'b0;
    ctx_waddr = in_addr;
    ctx_wdata = in_ch.context_value;
    if (state_r == ST_DEC) begin
      ctx_we    = !((mps_r == d_r) && a_r[mqe_pkg::A_W-1]);
      ctx_waddr = addr_r;
      ctx_wdata = nst_r;
    end else if (accept && (in_ch.cmd == mqe_pkg::CMD_LOAD)) begin
      ctx_we = load_ok;
    end
  end

  mqe_ctx_store #(
    .NUM_CONTEXTS (NUM_CONTEXTS),
    .AW           (AW)
  ) u_ctx (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctx_rd_en),
    .rd_addr (in_addr),
    .rd_data (ctx_rd_data),
    .wr_en   (ctx_we),
    .wr_addr (ctx_waddr),
    .wr_data (ctx_wdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer and coder registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      a_r        <= mqe_pkg::A_INIT;
      c_r        <= '0;
      ct_r       <= mqe_pkg::CT_INIT;
      pend_r     <= '0;
      dummy_r    <= 1'b1;
      hold_vld_r <= 1'b0;
      it_r       <= '0;
    end else begin
      if (emit_now) begin
        hold_r     <= emit_byte;
        hold_vld_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            addr_r <= in_addr;
            d_r    <= in_ch.decision;
            case (in_ch.cmd)
              mqe_pkg::CMD_ENCODE: begin
                if (in_range) begin
                  state_r <= ST_LOOK;
                end
              end
              mqe_pkg::CMD_FLUSH: begin
                state_r <= ST_FLIM;
              end
              mqe_pkg::CMD_START: begin
                a_r     <= mqe_pkg::A_INIT;
                c_r     <= '0;
                ct_r    <= mqe_pkg::CT_INIT;
                pend_r  <= '0;
                dummy_r <= 1'b1;
              end
              default: begin
                // load goes straight to the context store
              end
            endcase
          end
        end
        ST_LOOK: begin
          qe_r  <= mqe_pkg::QE_TAB[idx_c];
          mps_r <= st[0];
          if (st[0] == d_r) begin
            nst_r <= {mqe_pkg::NMPS_TAB[idx_c], st[0]};
          end else begin
            nst_r <= {mqe_pkg::NLPS_TAB[idx_c], st[0] ^ mqe_pkg::SW_TAB[idx_c]};
          end
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          a_r     <= a_r - qe_r;
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          it_r    <= '0;
          state_r <= ST_SHIFT;
          if (mps_r == d_r) begin
            if (a_r[mqe_pkg::A_W-1]) begin
              // interval still normalized: no shift, no state change
              c_r     <= c_r + mqe_pkg::C_W'(qe_r);
              state_r <= ST_IDLE;
            end else if (a_r < qe_r) begin
              a_r <= qe_r;
            end else begin
              c_r <= c_r + mqe_pkg::C_W'(qe_r);
            end
          end else begin
            if (a_r < qe_r) begin
              c_r <= c_r + mqe_pkg::C_W'(qe_r);
            end else begin
              a_r <= qe_r;
            end
          end
        end
        ST_SHIFT: begin
          a_r <= a_sh;
          if (form_now) begin
            c_r     <= fr.code;
            ct_r    <= fr.count;
            pend_r  <= fr.pend;
            dummy_r <= 1'b0;
          end else begin
            c_r  <= c_sh;
            ct_r <= ct_dec;
          end
          it_r <= it_r + 1'b1;
          if (a_sh[mqe_pkg::A_W-1] || (it_r == 4'd14)) begin
            state_r <= ST_END;
          end
        end
        ST_FLIM: begin
          lim_r   <= c_r + mqe_pkg::C_W'(a_r);
          c_r     <= c_r | mqe_pkg::C_FLUSH_OR;
          state_r <= ST_FCMP;
        end
        ST_FCMP: begin
          if (c_r >= lim_r) begin
            c_r <= c_r - mqe_pkg::C_FLUSH_SUB;
          end
          state_r <= ST_FSH1;
        end
        ST_FSH1, ST_FSH2: begin
          c_r     <= c_r << ct_r;
          state_r <= (state_r == ST_FSH1) ? ST_FFM1 : ST_FFM2;
        end
        ST_FFM1, ST_FFM2: begin
          c_r     <= fr.code;
          ct_r    <= fr.count;
          pend_r  <= fr.pend;
          dummy_r <= 1'b0;
          state_r <= (state_r == ST_FFM1) ? ST_FSH2 : ST_FFIN;
        end
        ST_FFIN: begin
          // drop a final 0xFF; the byte counts as sent from here on
          dummy_r <= 1'b1;
          state_r <= ST_END;
        end
        ST_END: begin
          hold_vld_r <= 1'b0;
          state_r    <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  mqe_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (out_ch.valid && out_ch.ready),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign out_ch.valid    = q_not_empty;
  assign out_ch.out_byte = head.data;
  assign out_ch.last     = head.last;

endmodule
`default_nettype wire

### sv/mqe_ctx_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_ctx_store: context probability state memory
// One write port, one registered read port; entries never written read zero.
// ----------------------------------------------------------------------------
module mqe_ctx_store #(
  parameter int NUM_CONTEXTS = 19,
  parameter int AW = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic [mqe_pkg::ST_W-1:0]      rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [mqe_pkg::ST_W-1:0] wr_data
);

  logic [mqe_pkg::ST_W-1:0] mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0]  vld_r;
  logic [mqe_pkg::ST_W-1:0] rd_q_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Unwritten entries hold the reset state zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

### sv/mqe_byte_former.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_byte_former: code byte formation
// Add a carry into the pending byte, release it, and take the next pending
// byte out of C with bit stuffing after 0xFF.
// ----------------------------------------------------------------------------
module mqe_byte_former (
  input  wire logic [mqe_pkg::BYTE_W-1:0] pend,
  input  wire logic [mqe_pkg::C_W-1:0]    code,
  input  wire logic                       dummy,
  output mqe_pkg::form_res_t              res
);

  logic                       carry;
  logic [mqe_pkg::BYTE_W-1:0] pend_c;
  logic [mqe_pkg::C_W-1:0]    code_c;

  always_comb begin
    carry  = (pend != mqe_pkg::BYTE_FF) && code[mqe_pkg::C_W-1];
    pend_c = carry ? pend + 8'd1 : pend;
    code_c = carry ? (code & mqe_pkg::C_CARRY_MSK) : code;

    res.emit = !dummy;
    res.data = pend_c;
    if (pend_c == mqe_pkg::BYTE_FF) begin
      // stuff: only seven code bits go into the next byte
      res.pend  = code_c[27:20];
      res.code  = code_c & mqe_pkg::C_STUFF_MSK;
      res.count = mqe_pkg::CT_STUFF;
    end else begin
      res.pend  = code_c[26:19];
      res.code  = code_c & mqe_pkg::C_PLAIN_MSK;
      res.count = mqe_pkg::CT_PLAIN;
    end
  end

endmodule
`default_nettype wire

### sv/mqe_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_out_fifo: code byte queue
// Small register queue between the coder and the output channel.
// ----------------------------------------------------------------------------
module mqe_out_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire mqe_pkg::out_item_t         push_item,
  input  wire logic                       pop,
  output mqe_pkg::out_item_t              head,
  output logic                            not_empty,
  output logic [mqe_pkg::OUT_CW-1:0]      count
);

  mqe_pkg::out_item_t          mem [mqe_pkg::OUT_DEPTH];
  logic [mqe_pkg::OUT_AW-1:0]  wr_ptr_r;
  logic [mqe_pkg::OUT_AW-1:0]  rd_ptr_r;
  logic [mqe_pkg::OUT_CW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + mqe_pkg::OUT_CW'(push) - mqe_pkg::OUT_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule
`default_nettype wire

### sv/mqe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_port_checks: port-level checks of the MQ arithmetic encoder
// Command timing and output channel behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module mqe_port_checks (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // flush keeps the block busy after its transfer
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == mqe_pkg::CMD_FLUSH) |=> !in_ready)
    else $error("ready after flush transfer");

  // start and load finish in their transfer cycle
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && ((in_cmd == mqe_pkg::CMD_START) || (in_cmd == mqe_pkg::CMD_LOAD))
    |=> in_ready)
    else $error("start or load did not complete in one cycle");

  // flush yields at least one byte: nothing may be accepted before it shows
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == mqe_pkg::CMD_FLUSH) |=> ##8 out_valid)
    else $error("no code byte after flush");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind mq_arithmetic_encoder mqe_port_checks u_mqe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);
`default_nettype wire

### test/mqe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqe_checker: code byte predictor and scoreboard for the MQ encoder
// Watches the command and code byte channels, runs its own MQ coder on every
// accepted command and compares each code byte transfer against the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module mqe_checker #(
  parameter int NUM_CONTEXTS = 19
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_context_index,
  input  logic       in_decision,
  input  logic [6:0] in_context_value,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         expect_count
);

  localparam int PROB_STATES = 47;

  localparam logic [15:0] PROB_QE [PROB_STATES] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601
  };

  localparam logic [5:0] AFTER_MPS [PROB_STATES] = '{
    6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46
  };

  localparam logic [5:0] AFTER_LPS [PROB_STATES] = '{
    6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46
  };

  localparam logic MPS_FLIP [PROB_STATES] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  // Coder state
  logic [15:0] intv_a;
  logic [27:0] code_reg;
  logic [3:0]  bit_ctr;
  logic [7:0]  held_byte;
  logic        held_dummy;
  logic [6:0]  ctx_state [NUM_CONTEXTS];

  mqe_pkg::out_item_t cmd_bytes[$];     // bytes of the command in progress
  mqe_pkg::out_item_t code_bytes_q[$];  // predicted bytes not yet seen

  task automatic put_byte(input logic [7:0] b);
    mqe_pkg::out_item_t it;
    if (cmd_bytes.size() < 3) begin
      it.data = b;
      it.last = 1'b0;
      cmd_bytes.push_back(it);
    end
  endtask

  // Apply a carry to the held byte, release it, and take the next byte from C.
  task automatic form_code_byte();
    if (held_byte != 8'hFF && code_reg[27]) begin
      held_byte   = held_byte + 8'd1;
      code_reg[27] = 1'b0;
    end
    if (!held_dummy)
      put_byte(held_byte);
    held_dummy = 1'b0;
    if (held_byte == 8'hFF) begin
      held_byte = code_reg[27:20];
      code_reg  = code_reg & 28'hFFFFF;
      bit_ctr   = 4'd7;
    end else begin
      held_byte = code_reg[26:19];
      code_reg  = code_reg & 28'h7FFFF;
      bit_ctr   = 4'd8;
    end
  endtask

  task automatic restart_coder();
    intv_a     = 16'h8000;
    code_reg   = '0;
    bit_ctr    = 4'd12;
    held_byte  = '0;
    held_dummy = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    logic [6:0]         st;
    int unsigned        idx;
    logic               mps;
    logic [15:0]        qe;
    logic [27:0]        limit;
    bit                 done;
    mqe_pkg::out_item_t want;
    if (!rst_n) begin
      restart_coder();
      for (int i = 0; i < NUM_CONTEXTS; i++)
        ctx_state[i] = '0;
      cmd_bytes.delete();
      code_bytes_q.delete();
      fail_count   = 0;
      expect_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (code_bytes_q.size() == 0) begin
          fail_count++;
          $display("%0t: code byte with none predicted: expected none, got %02h last=%0b",
                   $time, out_byte, out_last);
        end else begin
          want = code_bytes_q.pop_front();
          if (out_byte !== want.data) begin
            fail_count++;
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, want.data, out_byte);
          end
          if (out_last !== want.last) begin
            fail_count++;
            $display("%0t: last mismatch on byte %02h: expected %0b, got %0b",
                     $time, want.data, want.last, out_last);
          end
        end
      end

      if (in_valid && in_ready) begin
        cmd_bytes.delete();
        case (mqe_pkg::cmd_t'(in_cmd))
          mqe_pkg::CMD_ENCODE: begin
            if (in_context_index < NUM_CONTEXTS) begin
              st  = ctx_state[in_context_index];
              idx = st[6:1];
              mps = st[0];
              if (idx >= PROB_STATES)
                idx = PROB_STATES - 1;
              qe     = PROB_QE[idx];
              intv_a = intv_a - qe;
              done   = 1'b0;
              if (mps == in_decision) begin
                if (intv_a[15]) begin
                  // no renormalization, state unchanged
                  code_reg = code_reg + qe;
                  done     = 1'b1;
                end else begin
                  if (intv_a < qe)
                    intv_a = qe;
                  else
                    code_reg = code_reg + qe;
                  ctx_state[in_context_index] = {AFTER_MPS[idx], mps};
                end
              end else begin
                if (intv_a < qe)
                  code_reg = code_reg + qe;
                else
                  intv_a = qe;
                ctx_state[in_context_index] = {AFTER_LPS[idx], mps ^ MPS_FLIP[idx]};
              end
              for (int k = 0; k < 15 && !done; k++) begin
                intv_a   = intv_a << 1;
                code_reg = code_reg << 1;
                bit_ctr  = bit_ctr - 4'd1;
                if (bit_ctr == 4'd0)
                  form_code_byte();
                done = intv_a[15];
              end
            end
          end
          mqe_pkg::CMD_FLUSH: begin
            limit    = code_reg + intv_a;
            code_reg = code_reg | 28'hFFFF;
            if (code_reg >= limit)
              code_reg = code_reg - 28'h8000;
            code_reg = code_reg << bit_ctr;
            form_code_byte();
            code_reg = code_reg << bit_ctr;
            form_code_byte();
            // a trailing 0xFF is dropped
            if (held_byte != 8'hFF)
              put_byte(held_byte);
            held_dummy = 1'b1;
          end
          mqe_pkg::CMD_START: restart_coder();
          default: begin
            if (in_context_index < NUM_CONTEXTS && in_context_value < 2 * PROB_STATES)
              ctx_state[in_context_index] = in_context_value;
          end
        endcase
        for (int j = 0; j < cmd_bytes.size(); j++) begin
          want      = cmd_bytes[j];
          want.last = (j == cmd_bytes.size() - 1);
          code_bytes_q.push_back(want);
        end
      end
      expect_count = code_bytes_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the MQ arithmetic encoder
// Drives a directed command list and then random coding sessions (start,
// context loads, biased decisions, flush) mixed with stray commands, with
// random gaps on the command side and random stalls on the byte side. The
// checker beside the block predicts and compares every code byte.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_CTX       = 19;
  localparam int TARGET_CMDS = 280;
  localparam int DRAIN_WAIT  = 40;
  localparam int RUN_LIMIT   = 3000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   expect_count;
  int   useful_cmds;
  bit   no_idle;

  mqe_in_if  in_ch ();
  mqe_out_if out_ch ();

  mq_arithmetic_encoder #(.NUM_CONTEXTS(N_CTX)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mqe_checker #(.NUM_CONTEXTS(N_CTX)) code_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_cmd           (in_ch.cmd),
    .in_context_index (in_ch.context_index),
    .in_decision      (in_ch.decision),
    .in_context_value (in_ch.context_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_byte         (out_ch.out_byte),
    .out_last         (out_ch.last),
    .fail_count       (fail_count),
    .expect_count     (expect_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Present one command at a falling edge and hold it until the transfer.
  // Valid stays high from the previous command when there is no gap.
  task automatic send_cmd(input mqe_pkg::cmd_t c, input int ctx, input bit d,
                          input int val);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd           = c;
    in_ch.context_index = ctx[4:0];
    in_ch.decision      = d;
    in_ch.context_value = val[6:0];
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // ignored commands do not count toward the stimulus size
    if (!((c == mqe_pkg::CMD_ENCODE || c == mqe_pkg::CMD_LOAD) && ctx >= N_CTX) &&
        !(c == mqe_pkg::CMD_LOAD && val > 93))
      useful_cmds++;
  endtask

  // Hold off the next command until every predicted byte has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expect_count != 0) @(negedge clk);
  endtask

  // Byte side: ready runs and stalls of random length, with an occasional
  // long stretch of steady ready.
  initial begin : byte_sink
    int hi;
    int lo;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      lo = pick_gap();
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat (hi - 1) @(negedge clk);
      if (lo > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (lo - 1) @(negedge clk);
      end
    end
  end

  // Hard stop in case the block hangs or never delivers a predicted byte.
  initial begin
    #RUN_LIMIT;
    $display("[mq_arithmetic_encoder] ERROR");
    $finish;
  end

  initial begin : stimulus
    int   sel;
    int   n_ctx;
    int   n_dec;
    int   bias;
    int   pick;
    int   ctx_set [4];
    bit   fav [4];

    in_ch.valid         = 1'b0;
    in_ch.cmd           = mqe_pkg::CMD_ENCODE;
    in_ch.context_index = '0;
    in_ch.decision      = 1'b0;
    in_ch.context_value = '0;
    useful_cmds         = 0;
    no_idle             = 1'b0;
    rst_n               = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // --- directed part ---
    // Code straight out of reset, with context 0 in its reset state:
    // an MPS, then an LPS on the state that the MPS moved it to.
    send_cmd(mqe_pkg::CMD_ENCODE, 0, 1'b0, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 0, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_START, 0, 1'b0, 0);
    // Loads at the extremes; out-of-range context or state must be dropped.
    send_cmd(mqe_pkg::CMD_LOAD, 0, 1'b0, 93);
    send_cmd(mqe_pkg::CMD_LOAD, 18, 1'b0, 1);
    send_cmd(mqe_pkg::CMD_LOAD, 31, 1'b1, 127);
    send_cmd(mqe_pkg::CMD_LOAD, 19, 1'b0, 42);
    send_cmd(mqe_pkg::CMD_LOAD, 5, 1'b0, 94);
    send_cmd(mqe_pkg::CMD_LOAD, 6, 1'b1, 127);
    send_cmd(mqe_pkg::CMD_ENCODE, 0, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 0, 1'b0, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 18, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 18, 1'b0, 0);
    // Encodes to contexts past the store do nothing.
    send_cmd(mqe_pkg::CMD_ENCODE, 31, 1'b1, 127);
    send_cmd(mqe_pkg::CMD_ENCODE, 19, 1'b0, 0);
    // Smallest Qe: an LPS here renormalizes the full fifteen shifts.
    send_cmd(mqe_pkg::CMD_LOAD, 2, 1'b0, 90);
    send_cmd(mqe_pkg::CMD_ENCODE, 2, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 2, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_FLUSH, 0, 1'b0, 0);
    // Keep coding after a flush without a start, then flush twice in a row.
    send_cmd(mqe_pkg::CMD_ENCODE, 0, 1'b1, 0);
    send_cmd(mqe_pkg::CMD_ENCODE, 2, 1'b0, 0);
    send_cmd(mqe_pkg::CMD_FLUSH, 0, 1'b0, 0);
    send_cmd(mqe_pkg::CMD_FLUSH, 0, 1'b0, 0);
    // Flush right after start: only the terminating bytes appear.
    send_cmd(mqe_pkg::CMD_START, 0, 1'b0, 0);
    send_cmd(mqe_pkg::CMD_FLUSH, 0, 1'b0, 0);
    wait_drained();

    // --- random part ---
    while (useful_cmds < TARGET_CMDS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // stray commands with any field value
        repeat ($urandom_range(1, 4))
          send_cmd(mqe_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                   $urandom_range(0, 1), $urandom_range(0, 127));
      end else begin
        // one coding session over a few contexts with skewed symbols
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0)
          send_cmd(mqe_pkg::CMD_START, $urandom_range(0, 31), $urandom_range(0, 1),
                   $urandom_range(0, 127));
        n_ctx = $urandom_range(1, 4);
        bias  = $urandom_range(55, 98);
        for (int i = 0; i < n_ctx; i++) begin
          ctx_set[i] = $urandom_range(0, N_CTX - 1);
          fav[i]     = $urandom_range(0, 1);
          if ($urandom_range(0, 1))
            send_cmd(mqe_pkg::CMD_LOAD, ctx_set[i], $urandom_range(0, 1),
                     $urandom_range(0, 93));
        end
        n_dec = $urandom_range(4, 30);
        for (int i = 0; i < n_dec; i++) begin
          pick = $urandom_range(0, n_ctx - 1);
          send_cmd(mqe_pkg::CMD_ENCODE, ctx_set[pick],
                   ($urandom_range(0, 99) < bias) ? fav[pick] : !fav[pick],
                   $urandom_range(0, 127));
        end
        // now and then leave the session open so the next one runs on
        if ($urandom_range(0, 5) != 0)
          send_cmd(mqe_pkg::CMD_FLUSH, $urandom_range(0, 31), $urandom_range(0, 1),
                   $urandom_range(0, 127));
        no_idle = 1'b0;
        if ($urandom_range(0, 5) == 0)
          wait_drained();
      end
    end

    // Drop valid, drain every predicted byte, then give the block time to
    // show any byte that should not be there.
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0)
      $display("[mq_arithmetic_encoder] OK");
    else
      $display("[mq_arithmetic_encoder] ERROR");
    $finish;
  end

endmodule
